// ===== src/lshpg_pkg.sv =====
// Package for the LED strip HSV pattern generator: field widths, register and
// mode codes, sequencer states and the request/response structs of the serial units.
// No dependencies.
package lshpg_pkg;

	localparam int PER_W   = 14;   // period registers, remainders, offsets
	localparam int IDX_W   = 6;    // LED index
	localparam int HUE_W   = 16;
	localparam int SAT_W   = 8;
	localparam int VAL_W   = 8;
	localparam int CFG_W   = 16;   // widest register
	localparam int FCNT_W  = 32;   // frame counter
	localparam int STEP_W  = 6;    // divider step count
	localparam int OFF_W   = 20;   // period * LED index
	localparam int QDV_W   = 24;   // span * phase
	localparam int TRI_W   = 10;   // quotient of span * phase / period
	localparam int R_W     = 9;    // blend ratio, 0..256
	localparam int MIX_SH  = 8;    // blend ratio is in 1/256 steps

	localparam logic [PER_W-1:0] PERIOD_MAX = 14'd10000;

	localparam logic [TRI_W-1:0] SPAN_BLEND = 10'd512;
	localparam logic [TRI_W-1:0] PEAK_BLEND = 10'd256;
	localparam logic [TRI_W-1:0] SPAN_FADE  = 10'd510;
	localparam logic [TRI_W-1:0] PEAK_FADE  = 10'd255;
	localparam logic [VAL_W-1:0] VAL_FULL   = 8'd255;

	localparam logic [2:0]       RST_MODE       = 3'd1;
	localparam logic [HUE_W-1:0] RST_HUE_ONE    = 16'd0;
	localparam logic [SAT_W-1:0] RST_SAT_ONE    = 8'd255;
	localparam logic [HUE_W-1:0] RST_HUE_TWO    = 16'h1000;
	localparam logic [SAT_W-1:0] RST_SAT_TWO    = 8'd255;
	localparam logic [PER_W-1:0] RST_BLEND_PER  = 14'd4000;
	localparam logic [PER_W-1:0] RST_FADE_PER   = 14'd4000;
	localparam logic [PER_W-1:0] RST_ROTATE_PER = 14'd2000;

	typedef enum logic [2:0] {
		MODE_OFF    = 3'd0,
		MODE_ONE    = 3'd1,
		MODE_BLEND  = 3'd2,
		MODE_FADE   = 3'd3,
		MODE_ROTATE = 3'd4
	} mode_t;

	typedef enum logic [2:0] {
		REG_PATTERN_MODE  = 3'd0,
		REG_HUE_ONE       = 3'd1,
		REG_SAT_ONE       = 3'd2,
		REG_HUE_TWO       = 3'd3,
		REG_SAT_TWO       = 3'd4,
		REG_BLEND_PERIOD  = 3'd5,
		REG_FADE_PERIOD   = 3'd6,
		REG_ROTATE_PERIOD = 3'd7
	} cfg_reg_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_BASE,
		ST_LED,
		ST_OFF,
		ST_PHASE,
		ST_Q,
		ST_MIX,
		ST_OUT
	} state_t;

	typedef struct packed {
		logic              start;
		logic [STEP_W-1:0] steps;
	} div_req_t;

	typedef struct packed {
		logic done;
	} div_rsp_t;

	typedef struct packed {
		logic           start;
		logic [R_W-1:0] r;
	} mix_req_t;

	typedef struct packed {
		logic done;
	} mix_rsp_t;

endpackage

// ===== src/lshpg_div.sv =====
// Restoring divider, one quotient bit per cycle; the dividend is MSB-aligned by the caller.
// Depends on lshpg_pkg.
module lshpg_div
	import lshpg_pkg::*;
#(
	parameter int DIV_W = 42
) (
	input  logic              clk,
	input  logic              arst_n,
	input  div_req_t          req,
	input  logic [DIV_W-1:0]  dividend,
	input  logic [PER_W-1:0]  divisor,
	output div_rsp_t          rsp,
	output logic [PER_W-1:0]  quotient,
	output logic [PER_W-1:0]  remainder
);

	logic [DIV_W-1:0]  dvd_q;
	logic [PER_W-1:0]  den_q;
	logic [PER_W-1:0]  rem_q;
	logic [PER_W-1:0]  quo_q;
	logic [STEP_W-1:0] cnt_q;
	logic              done_q;

	logic [PER_W:0]    trial;
	logic [PER_W:0]    diff;
	logic              ge;

	always_comb begin
		trial = {rem_q, dvd_q[DIV_W-1]};
		diff  = trial - {1'b0, den_q};
		ge    = (trial >= {1'b0, den_q});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else if (req.start) begin
			cnt_q  <= req.steps;
			done_q <= 1'b0;
		end else if (cnt_q != '0) begin
			cnt_q  <= cnt_q - STEP_W'(1);
			done_q <= (cnt_q == STEP_W'(1));
		end else begin
			done_q <= 1'b0;
		end
	end

	// remainder stays below the divisor, so the trial difference fits PER_W bits
	always_ff @(posedge clk) begin
		if (req.start) begin
			dvd_q <= dividend;
			den_q <= divisor;
			rem_q <= '0;
			quo_q <= '0;
		end else if (cnt_q != '0) begin
			dvd_q <= dvd_q << 1;
			rem_q <= ge ? diff[PER_W-1:0] : trial[PER_W-1:0];
			quo_q <= {quo_q[PER_W-2:0], ge};
		end
	end

	assign rsp.done  = done_q;
	assign quotient  = quo_q;
	assign remainder = rem_q;

endmodule

// ===== src/lshpg_mix.sv =====
// Serial shift-add blender: b*256 + (a-b)*r for hue and saturation, one ratio bit per cycle.
// Depends on lshpg_pkg.
module lshpg_mix
	import lshpg_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  mix_req_t         req,
	input  logic [HUE_W-1:0] hue_a,
	input  logic [HUE_W-1:0] hue_b,
	input  logic [SAT_W-1:0] sat_a,
	input  logic [SAT_W-1:0] sat_b,
	output mix_rsp_t         rsp,
	output logic [HUE_W-1:0] hue_mix,
	output logic [SAT_W-1:0] sat_mix
);

	localparam int HACC_W = HUE_W + R_W + 1;
	localparam int SACC_W = SAT_W + R_W + 1;
	localparam int MCNT_W = $clog2(R_W + 1);

	logic [R_W-1:0]    r_q;
	logic [HACC_W-1:0] mh_q;
	logic [HACC_W-1:0] acc_h_q;
	logic [SACC_W-1:0] ms_q;
	logic [SACC_W-1:0] acc_s_q;
	logic [MCNT_W-1:0] cnt_q;
	logic              done_q;

	logic [HUE_W:0]    diff_h;
	logic [SAT_W:0]    diff_s;

	// differences are two's complement; the final sum is known non-negative
	always_comb begin
		diff_h = {1'b0, hue_a} - {1'b0, hue_b};
		diff_s = {1'b0, sat_a} - {1'b0, sat_b};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else if (req.start) begin
			cnt_q  <= MCNT_W'(R_W);
			done_q <= 1'b0;
		end else if (cnt_q != '0) begin
			cnt_q  <= cnt_q - MCNT_W'(1);
			done_q <= (cnt_q == MCNT_W'(1));
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			r_q     <= req.r;
			mh_q    <= {{(HACC_W-HUE_W-1){diff_h[HUE_W]}}, diff_h};
			ms_q    <= {{(SACC_W-SAT_W-1){diff_s[SAT_W]}}, diff_s};
			acc_h_q <= HACC_W'({hue_b, {MIX_SH{1'b0}}});
			acc_s_q <= SACC_W'({sat_b, {MIX_SH{1'b0}}});
		end else if (cnt_q != '0) begin
			if (r_q[0]) begin
				acc_h_q <= acc_h_q + mh_q;
				acc_s_q <= acc_s_q + ms_q;
			end
			r_q  <= r_q >> 1;
			mh_q <= mh_q << 1;
			ms_q <= ms_q << 1;
		end
	end

	assign rsp.done = done_q;
	assign hue_mix  = acc_h_q[HUE_W+MIX_SH-1:MIX_SH];
	assign sat_mix  = acc_s_q[SAT_W+MIX_SH-1:MIX_SH];

endmodule

// ===== src/led_strip_hsv_pattern_generator_unit.sv =====
// Top level of the LED strip HSV pattern generator: registers, frame counter, LED sequencer.
// Depends on lshpg_pkg, lshpg_div and lshpg_mix.
//
//  channel  | handshake          | payload
//  ---------+--------------------+---------------------------------------------
//  input    | in_valid/in_ready  | frame_tick
//  output   | out_valid/out_ready| led_index, hue, saturation, value, last_led
//  config   | cfg_we             | cfg_index, cfg_wdata
//
// A tick with frame_tick set yields NUM_LEDS results. Off, unknown and one-colour frames
// go straight from the LED state to output. Blend, fade and rotating frames first divide
// the scaled frame count by the period, then per LED run the offset division (rotating
// only), the phase division and the blend (not fade). The shared serial divider and the
// serial blender (one bit per cycle) do this work. Ticks are taken only between frames;
// the last result may still sit in the output register then. A stalled output holds the
// sequencer in its output state. Reset loads the register defaults and clears the counter.
module led_strip_hsv_pattern_generator_unit
	import lshpg_pkg::*;
#(
	parameter int NUM_LEDS = 16,
	parameter int FRAME_MS = 30
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic [2:0]       cfg_index,
	input  logic [CFG_W-1:0] cfg_wdata,
	input  logic             in_valid,
	output logic             in_ready,
	input  logic             frame_tick,
	output logic             out_valid,
	input  logic             out_ready,
	output logic [IDX_W-1:0] led_index,
	output logic [HUE_W-1:0] hue,
	output logic [SAT_W-1:0] saturation,
	output logic [VAL_W-1:0] value,
	output logic             last_led
);

	localparam int BASE_W = FCNT_W + $clog2(FRAME_MS + 1);
	localparam int DIV_W  = (BASE_W > QDV_W) ? BASE_W : QDV_W;

	// configuration
	logic [2:0]        mode_q;
	logic [HUE_W-1:0]  hue_one_q;
	logic [SAT_W-1:0]  sat_one_q;
	logic [HUE_W-1:0]  hue_two_q;
	logic [SAT_W-1:0]  sat_two_q;
	logic [PER_W-1:0]  blend_per_q;
	logic [PER_W-1:0]  fade_per_q;
	logic [PER_W-1:0]  rot_per_q;
	logic [FCNT_W-1:0] frame_count_q;
	logic [BASE_W-1:0] base_q;    // FRAME_MS * frame_count

	// sequencer
	state_t            state_q;
	state_t            state_nxt;
	logic [IDX_W-1:0]  led_q;
	logic [PER_W-1:0]  basemod_q;
	logic [PER_W-1:0]  off_q;
	logic [R_W-1:0]    tri_q;

	// output register
	logic              out_valid_q;
	logic [IDX_W-1:0]  led_index_q;
	logic [HUE_W-1:0]  hue_q;
	logic [SAT_W-1:0]  sat_q;
	logic [VAL_W-1:0]  val_q;
	logic              last_q;

	mode_t             mode;
	logic              needs_phase;
	logic              per_ok;
	logic              tick_go;
	logic              out_free;
	logic              is_last;
	logic [PER_W-1:0]  per_sel;
	logic [TRI_W-1:0]  span;
	logic [TRI_W-1:0]  peak;
	logic [PER_W:0]    phase_sum;
	logic [PER_W-1:0]  phase_t;
	logic [QDV_W-1:0]  span_t;
	logic [OFF_W-1:0]  off_prod;
	logic [TRI_W-1:0]  q_val;
	logic [TRI_W-1:0]  tri_full;
	logic [R_W-1:0]    tri_r;
	logic [HUE_W-1:0]  res_hue;
	logic [SAT_W-1:0]  res_sat;
	logic [VAL_W-1:0]  res_val;

	div_req_t          div_req;
	div_rsp_t          div_rsp;
	logic [DIV_W-1:0]  div_dividend;
	logic [PER_W-1:0]  div_divisor;
	logic [PER_W-1:0]  div_quo;
	logic [PER_W-1:0]  div_rem;
	mix_req_t          mix_req;
	mix_rsp_t          mix_rsp;
	logic [HUE_W-1:0]  mix_hue;
	logic [SAT_W-1:0]  mix_sat;

	assign mode     = mode_t'(mode_q);
	assign per_ok   = (cfg_wdata[PER_W-1:0] != '0) && (cfg_wdata[PER_W-1:0] <= PERIOD_MAX);
	assign in_ready = (state_q == ST_IDLE);
	assign tick_go  = in_valid && in_ready && frame_tick;
	assign out_free = !out_valid_q || out_ready;
	assign is_last  = (led_q == IDX_W'(NUM_LEDS - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q      <= RST_MODE;
			hue_one_q   <= RST_HUE_ONE;
			sat_one_q   <= RST_SAT_ONE;
			hue_two_q   <= RST_HUE_TWO;
			sat_two_q   <= RST_SAT_TWO;
			blend_per_q <= RST_BLEND_PER;
			fade_per_q  <= RST_FADE_PER;
			rot_per_q   <= RST_ROTATE_PER;
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_PATTERN_MODE:  mode_q    <= cfg_wdata[2:0];
				REG_HUE_ONE:       hue_one_q <= cfg_wdata[HUE_W-1:0];
				REG_SAT_ONE:       sat_one_q <= cfg_wdata[SAT_W-1:0];
				REG_HUE_TWO:       hue_two_q <= cfg_wdata[HUE_W-1:0];
				REG_SAT_TWO:       sat_two_q <= cfg_wdata[SAT_W-1:0];
				REG_BLEND_PERIOD:  if (per_ok) blend_per_q <= cfg_wdata[PER_W-1:0];
				REG_FADE_PERIOD:   if (per_ok) fade_per_q  <= cfg_wdata[PER_W-1:0];
				REG_ROTATE_PERIOD: if (per_ok) rot_per_q   <= cfg_wdata[PER_W-1:0];
				default: ;
			endcase
		end
	end

	// counter and scaled copy advance together, clear on a mode write; the copy zeroes on wrap
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_count_q <= '0;
			base_q        <= '0;
		end else if (cfg_we && (cfg_reg_t'(cfg_index) == REG_PATTERN_MODE)) begin
			frame_count_q <= '0;
			base_q        <= '0;
		end else if (tick_go) begin
			frame_count_q <= frame_count_q + FCNT_W'(1);
			base_q        <= (&frame_count_q) ? '0 : base_q + BASE_W'(FRAME_MS);
		end
	end

	always_comb begin
		needs_phase = 1'b0;
		per_sel     = blend_per_q;
		span        = SPAN_BLEND;
		peak        = PEAK_BLEND;
		res_hue     = '0;
		res_sat     = '0;
		res_val     = '0;
		case (mode) inside
			MODE_ONE: begin
				res_hue = hue_one_q;
				res_sat = sat_one_q;
				res_val = VAL_FULL;
			end
			MODE_BLEND: begin
				needs_phase = 1'b1;
				res_hue     = mix_hue;
				res_sat     = mix_sat;
				res_val     = VAL_FULL;
			end
			MODE_FADE: begin
				needs_phase = 1'b1;
				per_sel     = fade_per_q;
				span        = SPAN_FADE;
				peak        = PEAK_FADE;
				res_hue     = hue_one_q;
				res_sat     = sat_one_q;
				res_val     = tri_q[VAL_W-1:0];
			end
			MODE_ROTATE: begin
				needs_phase = 1'b1;
				per_sel     = rot_per_q;
				res_hue     = mix_hue;
				res_sat     = mix_sat;
				res_val     = VAL_FULL;
			end
			default: ;
		endcase
	end

	// both terms are below the period, so one conditional subtract wraps the phase
	always_comb begin
		phase_sum = {1'b0, basemod_q} + {1'b0, off_q};
		phase_t   = (phase_sum >= {1'b0, per_sel}) ?
		            PER_W'(phase_sum - {1'b0, per_sel}) : phase_sum[PER_W-1:0];
		span_t    = QDV_W'(phase_t) * QDV_W'(span);
		off_prod  = OFF_W'(per_sel) * OFF_W'(led_q);
		q_val     = div_quo[TRI_W-1:0];
		tri_full  = (q_val >= peak) ? (q_val - peak) : (peak - q_val);
		tri_r     = tri_full[R_W-1:0];
	end

	always_comb begin
		state_nxt     = state_q;
		div_req       = '0;
		div_dividend  = '0;
		div_divisor   = per_sel;
		mix_req       = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (tick_go) begin
					if (needs_phase) begin
						div_req.start = 1'b1;
						div_req.steps = STEP_W'(BASE_W);
						div_dividend  = DIV_W'(base_q) << (DIV_W - BASE_W);
						state_nxt     = ST_BASE;
					end else begin
						state_nxt = ST_LED;
					end
				end
			end
			ST_BASE: begin
				if (div_rsp.done) state_nxt = ST_LED;
			end
			ST_LED: begin
				if (mode == MODE_ROTATE) begin
					div_req.start = 1'b1;
					div_req.steps = STEP_W'(OFF_W);
					div_dividend  = DIV_W'(off_prod) << (DIV_W - OFF_W);
					div_divisor   = PER_W'(NUM_LEDS);
					state_nxt     = ST_OFF;
				end else if (needs_phase) begin
					state_nxt = ST_PHASE;
				end else begin
					state_nxt = ST_OUT;
				end
			end
			ST_OFF: begin
				if (div_rsp.done) state_nxt = ST_PHASE;
			end
			ST_PHASE: begin
				div_req.start = 1'b1;
				div_req.steps = STEP_W'(QDV_W);
				div_dividend  = DIV_W'(span_t) << (DIV_W - QDV_W);
				state_nxt     = ST_Q;
			end
			ST_Q: begin
				if (div_rsp.done) begin
					if (mode == MODE_FADE) begin
						state_nxt = ST_OUT;
					end else begin
						mix_req.start = 1'b1;
						mix_req.r     = tri_r;
						state_nxt     = ST_MIX;
					end
				end
			end
			ST_MIX: begin
				if (mix_rsp.done) state_nxt = ST_OUT;
			end
			ST_OUT: begin
				if (out_free) state_nxt = is_last ? ST_IDLE : ST_LED;
			end
			default: state_nxt = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			led_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (state_q == ST_OUT && out_free) begin
				led_q       <= is_last ? '0 : led_q + IDX_W'(1);
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_BASE && div_rsp.done) basemod_q <= div_rem;
		if (state_q == ST_LED && mode != MODE_ROTATE) off_q <= '0;
		if (state_q == ST_OFF && div_rsp.done) off_q <= div_quo;
		if (state_q == ST_Q && div_rsp.done) tri_q <= tri_r;
		if (state_q == ST_OUT && out_free) begin
			led_index_q <= led_q;
			hue_q       <= res_hue;
			sat_q       <= res_sat;
			val_q       <= res_val;
			last_q      <= is_last;
		end
	end

	lshpg_div #(
		.DIV_W(DIV_W)
	) u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (div_req),
		.dividend  (div_dividend),
		.divisor   (div_divisor),
		.rsp       (div_rsp),
		.quotient  (div_quo),
		.remainder (div_rem)
	);

	lshpg_mix u_mix (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (mix_req),
		.hue_a   (hue_one_q),
		.hue_b   (hue_two_q),
		.sat_a   (sat_one_q),
		.sat_b   (sat_two_q),
		.rsp     (mix_rsp),
		.hue_mix (mix_hue),
		.sat_mix (mix_sat)
	);

	assign out_valid  = out_valid_q;
	assign led_index  = led_index_q;
	assign hue        = hue_q;
	assign saturation = sat_q;
	assign value      = val_q;
	assign last_led   = last_q;

	// a frame transfer moves the counter on by exactly one
	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		(tick_go && !cfg_we) |=> (frame_count_q == $past(frame_count_q) + FCNT_W'(1)))
		else $error("frame counter did not advance on frame start");

	a_led_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_IDLE) |-> ({1'b0, led_q} < (IDX_W + 1)'(NUM_LEDS)))
		else $error("LED index beyond strip length");

	a_div_owner: assert property (@(posedge clk) disable iff (!arst_n)
		div_rsp.done |-> (state_q == ST_BASE || state_q == ST_OFF || state_q == ST_Q))
		else $error("divider finished outside a division state");

	a_mix_owner: assert property (@(posedge clk) disable iff (!arst_n)
		mix_rsp.done |-> (state_q == ST_MIX))
		else $error("blender finished outside the blend state");

endmodule

// ===== bench/tb_led_strip_hsv_pattern_generator_unit.sv =====
// Testbench for led_strip_hsv_pattern_generator_unit: a table of directed frames, then random
// register settings and frame ticks, each frame checked LED by LED against a local predictor.
// Depends on lshpg_pkg and the generator RTL.
`timescale 1ns / 100ps

module tb_led_strip_hsv_pattern_generator_unit;
	import lshpg_pkg::*;

	localparam int LEDS       = 16;
	localparam int FRAME_MS   = 30;
	localparam int PER_LIMIT  = 10000;
	localparam int RAND_TICKS = 500;
	localparam int SETTLE_CYC = 20;
	localparam int DRAIN_CYC  = 64;
	localparam int HOLD_CYC   = 3000;
	localparam int LIMIT_CYC  = 3000000;
	localparam int DIR_N      = 39;

	typedef struct packed {
		logic [IDX_W-1:0] idx;
		logic [HUE_W-1:0] h;
		logic [SAT_W-1:0] s;
		logic [VAL_W-1:0] v;
		logic             last;
	} led_px_t;

	typedef enum logic {ROW_CFG, ROW_TICK} row_kind_e;

	typedef struct {
		row_kind_e        kind;
		cfg_reg_t         ridx;
		logic [CFG_W-1:0] data;
		bit               tick;
		bit               typed;
		logic [HUE_W-1:0] h;
		logic [SAT_W-1:0] s;
		logic [VAL_W-1:0] v;
	} stim_row_t;

	typedef enum int {RX_FREE, RX_LIGHT, RX_HEAVY, RX_PERIODIC} rx_style_e;

	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	logic             cfg_we = 1'b0;
	logic [2:0]       cfg_index = REG_PATTERN_MODE;
	logic [CFG_W-1:0] cfg_wdata = '0;
	logic             in_valid = 1'b0;
	logic             in_ready;
	logic             frame_tick = 1'b0;
	logic             out_valid;
	logic             out_ready = 1'b0;
	logic [IDX_W-1:0] led_index;
	logic [HUE_W-1:0] hue;
	logic [SAT_W-1:0] saturation;
	logic [VAL_W-1:0] value;
	logic             last_led;

	// predictor copy of the registers and the frame counter
	logic [2:0]  pat_mode = MODE_ONE;
	int unsigned col1_hue = 0;
	int unsigned col1_sat = 255;
	int unsigned col2_hue = 16'h1000;
	int unsigned col2_sat = 255;
	int unsigned blend_ms = 4000;
	int unsigned fade_ms  = 4000;
	int unsigned rot_ms   = 2000;
	logic [31:0] frames_seen = '0;

	led_px_t frame_buf [LEDS];
	led_px_t due_pixels[$];
	int      pixel_errs = 0;
	int      cycles = 0;
	bit      hold_go = 1'b0;

	led_strip_hsv_pattern_generator_unit #(
		.NUM_LEDS(LEDS),
		.FRAME_MS(FRAME_MS)
	) dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.frame_tick(frame_tick),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.led_index (led_index),
		.hue       (hue),
		.saturation(saturation),
		.value     (value),
		.last_led  (last_led)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > LIMIT_CYC) begin
			$display("FAIL");
			$finish;
		end
	end

	// (FRAME_MS*count + shift) mod period, formed in 64 bits
	function automatic int unsigned phase_ms(int unsigned per, int unsigned shift);
		longint unsigned e;
		e = FRAME_MS;
		e = e * frames_seen + shift;
		return int'(e % per);
	endfunction

	function automatic int unsigned tri_wave(int unsigned t, int unsigned per,
			int unsigned span, int unsigned peak);
		int unsigned q;
		q = (span * t) / per;
		return (q >= peak) ? q - peak : peak - q;
	endfunction

	function automatic int unsigned blend_mix(int unsigned a, int unsigned b, int unsigned r);
		return (a * r + b * (256 - r)) / 256;
	endfunction

	function automatic void apply_reg(cfg_reg_t ri, logic [CFG_W-1:0] d);
		int unsigned per;
		bit          per_ok;
		per = d[PER_W-1:0];
		per_ok = per >= 1 && per <= PER_LIMIT;
		case (ri)
			REG_PATTERN_MODE: begin
				pat_mode = d[2:0];
				frames_seen = '0;
			end
			REG_HUE_ONE:       col1_hue = d;
			REG_SAT_ONE:       col1_sat = d[SAT_W-1:0];
			REG_HUE_TWO:       col2_hue = d;
			REG_SAT_TWO:       col2_sat = d[SAT_W-1:0];
			REG_BLEND_PERIOD:  if (per_ok) blend_ms = per;
			REG_FADE_PERIOD:   if (per_ok) fade_ms = per;
			REG_ROTATE_PERIOD: if (per_ok) rot_ms = per;
			default: ;
		endcase
	endfunction

	// one frame of pixels into frame_buf, then advance the counter
	function automatic void render_frame();
		int unsigned h, s, v, r, shift;
		for (int i = 0; i < LEDS; i++) begin
			h = 0;
			s = 0;
			v = 0;
			case (pat_mode)
				MODE_ONE: begin
					h = col1_hue;
					s = col1_sat;
					v = 255;
				end
				MODE_BLEND: begin
					r = tri_wave(phase_ms(blend_ms, 0), blend_ms, 512, 256);
					h = blend_mix(col1_hue, col2_hue, r);
					s = blend_mix(col1_sat, col2_sat, r);
					v = 255;
				end
				MODE_FADE: begin
					h = col1_hue;
					s = col1_sat;
					v = tri_wave(phase_ms(fade_ms, 0), fade_ms, 510, 255);
				end
				MODE_ROTATE: begin
					shift = (rot_ms * i) / LEDS;
					r = tri_wave(phase_ms(rot_ms, shift), rot_ms, 512, 256);
					h = blend_mix(col1_hue, col2_hue, r);
					s = blend_mix(col1_sat, col2_sat, r);
					v = 255;
				end
				default: ;	// off and the unused codes give a dark frame
			endcase
			frame_buf[i] = {IDX_W'(i), HUE_W'(h), SAT_W'(s), VAL_W'(v), i == LEDS - 1};
		end
		frames_seen = frames_seen + 1;
	endfunction

	task automatic settle();
		while (due_pixels.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYC) @(posedge clk);
	endtask

	task automatic write_reg(input cfg_reg_t ri, input logic [CFG_W-1:0] d);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= ri;
		cfg_wdata <= d;
		@(posedge clk);
		apply_reg(ri, d);
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	// leaves in_valid high; the caller drops it
	task automatic offer_tick(input bit tk, input bit typed, input logic [HUE_W-1:0] th,
			input logic [SAT_W-1:0] ts, input logic [VAL_W-1:0] tv);
		led_px_t px;
		@(negedge clk);
		in_valid <= 1'b1;
		frame_tick <= tk;
		do
			@(posedge clk);
		while (in_ready !== 1'b1);
		if (tk) begin
			render_frame();
			for (int i = 0; i < LEDS; i++) begin
				px = frame_buf[i];
				if (typed) begin
					px.h = th;
					px.s = ts;
					px.v = tv;
				end
				due_pixels.push_back(px);
			end
		end
	endtask

	always @(posedge clk) begin
		led_px_t got, want;
		if (arst_n && out_valid && out_ready) begin
			got = {led_index, hue, saturation, value, last_led};
			if (due_pixels.size() == 0) begin
				pixel_errs++;
				if (pixel_errs <= 10)
					$display("unexpected pixel: led %0d hue %h sat %h val %h last %b",
						got.idx, got.h, got.s, got.v, got.last);
			end else begin
				want = due_pixels.pop_front();
				if (got !== want) begin
					pixel_errs++;
					if (pixel_errs <= 10)
						$display({"pixel mismatch: led %0d/%0d hue %h/%h sat %h/%h ",
							"val %h/%h last %b/%b (exp/got)"},
							want.idx, got.idx, want.h, got.h, want.s, got.s,
							want.v, got.v, want.last, got.last);
				end
			end
		end
	end

	// receiver: segments of differing stall density, plus one long hold-off on request
	initial begin
		rx_style_e style;
		int        seg_left;
		seg_left = 0;
		style = RX_FREE;
		forever begin
			@(negedge clk);
			if (hold_go) begin
				hold_go = 1'b0;
				out_ready <= 1'b0;
				repeat (HOLD_CYC) @(negedge clk);
			end else begin
				if (seg_left == 0) begin
					style = rx_style_e'($urandom_range(0, 3));
					seg_left = $urandom_range(10, 300);
				end
				seg_left--;
				case (style)
					RX_FREE:   out_ready <= 1'b1;
					RX_LIGHT:  out_ready <= $urandom_range(0, 9) < 7;
					RX_HEAVY:  out_ready <= $urandom_range(0, 3) == 0;
					default:   out_ready <= (seg_left % 5) == 0;
				endcase
			end
		end
	end

	initial begin
		stim_row_t        dir_rows [DIR_N];
		logic [CFG_W-1:0] d;
		int               ticks_done, phase_no, n, burst_left, gap;
		bit               tk;

		dir_rows = '{
			// defaults after reset: one colour, hue 0, full saturation
			'{ROW_TICK, REG_PATTERN_MODE, 16'h0, 1'b1, 1'b1, 16'h0000, 8'hFF, 8'hFF},
			'{ROW_TICK, REG_PATTERN_MODE, 16'h0, 1'b0, 1'b0, 16'h0000, 8'h00, 8'h00},
			'{ROW_TICK, REG_PATTERN_MODE, 16'h0, 1'b1, 1'b1, 16'h0000, 8'hFF, 8'hFF},
			'{ROW_CFG,  REG_HUE_ONE,      16'hFFFF, 1'b0, 1'b0, 16'h0, 8'h0, 8'h0},
			'{ROW_CFG,  REG_SAT_ONE,      16'h0000, 1'b0, 1'b0, 16'h0, 8'h0, 8'h0},
			'{ROW_TICK, REG_PATTERN_MODE, 16'h0, 1'b1, 1'b1, 16'hFFFF, 8'h00, 8'hFF},
			'{ROW_CFG,  REG_PATTERN_MODE, 16'(MODE_OFF), 1'b0, 1'b0, 16'h0, 8'h0, 8'h0},
			'{ROW_TICK, REG_PATTERN_MODE, 16'h0, 1'b1, 1'b1, 16'h0000, 8'h00, 8'h00},
			// all ones: mode field reads 7, no pattern behind it
			'{ROW_CFG,  REG_PATTERN_MODE, 16'hFFFF, 1'b0, 1'b0, 16'h0, 8'h0, 8'h0},
			'{ROW_TICK, REG_PATTERN_MODE, 16'h0, 1'b1, 1'b1, 16'h0000, 8'h00, 8'h00},
			'{ROW_TICK, REG_PATTERN_MODE, 16'h0, 1'b1, 1'b1, 16'h0000, 8'h00, 8'h00},
			'{ROW_CFG,  REG_HUE_TWO,      16'h0000, 1'b0, 1'b0, 16'h0, 8'h0, 8'h0},
			'{ROW_CFG,  REG_SAT_TWO,      16'h00FF, 1'b0, 1'b0, 16'h0, 8'h0, 8'h0},
			// 1 ms period: elapsed time is always 0, so colour one throughout
			'{ROW_CFG,  REG_BLEND_PERIOD, 16'd1, 1'b0, 1'b0, 16'h0, 8'h0, 8'h0},
			'{ROW_CFG,  REG_PATTERN_MODE, 16'(MODE_BLEND), 1'b0, 1'b0, 16'h0, 8'h0, 8'h0},
			'{ROW_TICK, REG_PATTERN_MODE, 16'h0, 1'b1, 1'b1, 16'hFFFF, 8'h00, 8'hFF},
			'{ROW_TICK, REG_PATTERN_MODE, 16'h0, 1'b1, 1'b1, 16'hFFFF, 8'h00, 8'hFF},
			'{ROW_CFG,  REG_BLEND_PERIOD, 16'd10000, 1'b0, 1'b0, 16'h0, 8'h0, 8'h0},
			// out of range, must leave 10000 in place
			'{ROW_CFG,  REG_BLEND_PERIOD, 16'd0, 1'b0, 1'b0, 16'h0, 8'h0, 8'h0},
			'{ROW_CFG,  REG_BLEND_PERIOD, 16'd10001, 1'b0, 1'b0, 16'h0, 8'h0, 8'h0},
			'{ROW_CFG,  REG_PATTERN_MODE, 16'(MODE_BLEND), 1'b0, 1'b0, 16'h0, 8'h0, 8'h0},
			'{ROW_TICK, REG_PATTERN_MODE, 16'h0, 1'b1, 1'b1, 16'hFFFF, 8'h00, 8'hFF},
			'{ROW_TICK, REG_PATTERN_MODE, 16'h0, 1'b1, 1'b0, 16'h0, 8'h0, 8'h0},
			'{ROW_TICK, REG_PATTERN_MODE, 16'h0, 1'b1, 1'b0, 16'h0, 8'h0, 8'h0},
			'{ROW_CFG,  REG_FADE_PERIOD,  16'd10000, 1'b0, 1'b0, 16'h0, 8'h0, 8'h0},
			'{ROW_CFG,  REG_PATTERN_MODE, 16'(MODE_FADE), 1'b0, 1'b0, 16'h0, 8'h0, 8'h0},
			'{ROW_TICK, REG_PATTERN_MODE, 16'h0, 1'b1, 1'b1, 16'hFFFF, 8'h00, 8'hFF},
			'{ROW_TICK, REG_PATTERN_MODE, 16'h0, 1'b1, 1'b0, 16'h0, 8'h0, 8'h0},
			'{ROW_TICK, REG_PATTERN_MODE, 16'h0, 1'b1, 1'b0, 16'h0, 8'h0, 8'h0},
			'{ROW_CFG,  REG_FADE_PERIOD,  16'd1, 1'b0, 1'b0, 16'h0, 8'h0, 8'h0},
			'{ROW_TICK, REG_PATTERN_MODE, 16'h0, 1'b1, 1'b1, 16'hFFFF, 8'h00, 8'hFF},
			'{ROW_CFG,  REG_ROTATE_PERIOD, 16'd10000, 1'b0, 1'b0, 16'h0, 8'h0, 8'h0},
			'{ROW_CFG,  REG_PATTERN_MODE, 16'(MODE_ROTATE), 1'b0, 1'b0, 16'h0, 8'h0, 8'h0},
			'{ROW_TICK, REG_PATTERN_MODE, 16'h0, 1'b1, 1'b0, 16'h0, 8'h0, 8'h0},
			'{ROW_TICK, REG_PATTERN_MODE, 16'h0, 1'b1, 1'b0, 16'h0, 8'h0, 8'h0},
			// rewriting the same mode still restarts the counter
			'{ROW_CFG,  REG_PATTERN_MODE, 16'(MODE_ROTATE), 1'b0, 1'b0, 16'h0, 8'h0, 8'h0},
			'{ROW_TICK, REG_PATTERN_MODE, 16'h0, 1'b1, 1'b0, 16'h0, 8'h0, 8'h0},
			'{ROW_CFG,  REG_ROTATE_PERIOD, 16'd1, 1'b0, 1'b0, 16'h0, 8'h0, 8'h0},
			'{ROW_TICK, REG_PATTERN_MODE, 16'h0, 1'b1, 1'b1, 16'hFFFF, 8'h00, 8'hFF}
		};

		repeat (6) @(negedge clk);
		arst_n <= 1'b1;

		foreach (dir_rows[k]) begin
			if (dir_rows[k].kind == ROW_CFG) begin
				settle();
				write_reg(dir_rows[k].ridx, dir_rows[k].data);
			end else begin
				offer_tick(dir_rows[k].tick, dir_rows[k].typed, dir_rows[k].h,
					dir_rows[k].s, dir_rows[k].v);
				@(negedge clk);
				in_valid <= 1'b0;
			end
		end

		ticks_done = 0;
		phase_no = 0;
		burst_left = 0;
		while (ticks_done < RAND_TICKS) begin
			settle();
			for (int r = 0; r < 8; r++) begin
				if ($urandom_range(0, 1) == 0)
					continue;
				d = 16'($urandom);
				case (cfg_reg_t'(r))
					REG_PATTERN_MODE: begin
						d[2:0] = ($urandom_range(0, 9) == 0) ? 3'($urandom_range(5, 7))
							: 3'($urandom_range(0, 4));
						if ($urandom_range(0, 1) != 0)
							d[CFG_W-1:3] = '0;
					end
					REG_HUE_ONE, REG_HUE_TWO:
						case ($urandom_range(0, 5))
							0: d = 16'h0000;
							1: d = 16'hFFFF;
							default: ;
						endcase
					REG_SAT_ONE, REG_SAT_TWO:
						case ($urandom_range(0, 5))
							0: d = 16'h0000;
							1: d = 16'h00FF;
							2: ;	// upper bits set, ignored by the register
							default: d[CFG_W-1:SAT_W] = '0;
						endcase
					default:
						case ($urandom_range(0, 9))
							0: d = 16'd1;
							1: d = 16'(PER_LIMIT);
							2, 3: d = 16'($urandom_range(1, 64));
							4, 5: d = 16'($urandom_range(1, 600));
							6: d = 16'($urandom_range(600, PER_LIMIT));
							7: d = 16'd0;
							8: d = 16'($urandom_range(PER_LIMIT + 1, 16383));
							default: ;	// any 16 bits, upper two ignored
						endcase
				endcase
				write_reg(cfg_reg_t'(r), d);
			end

			// second phase: receiver stops for a long while so the block backs up
			if (phase_no == 1)
				hold_go = 1'b1;

			n = $urandom_range(6, 40);
			for (int k = 0; k < n; k++) begin
				tk = $urandom_range(0, 11) != 0;
				offer_tick(tk, 1'b0, '0, '0, '0);
				if (tk)
					ticks_done++;
				if (burst_left == 0) begin
					gap = $urandom_range(1, 20);
					@(negedge clk);
					in_valid <= 1'b0;
					repeat (gap - 1) @(negedge clk);
					burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
						: $urandom_range(1, 8);
				end else begin
					burst_left--;
				end
			end
			@(negedge clk);
			in_valid <= 1'b0;
			phase_no++;
		end

		while (due_pixels.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYC) @(posedge clk);
		if (pixel_errs == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule

// ===== files.f =====
src/lshpg_pkg.sv
src/lshpg_div.sv
src/lshpg_mix.sv
src/led_strip_hsv_pattern_generator_unit.sv
bench/tb_led_strip_hsv_pattern_generator_unit.sv
